// ===== rtl/core/cbm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

  typedef logic [2:0] kind_t;
  typedef logic [1:0] target_t;
  typedef logic [1:0] reg_idx_t;

  localparam kind_t KIND_ROM  = 3'd0;
  localparam kind_t KIND_MBC1 = 3'd1;
  localparam kind_t KIND_MBC2 = 3'd2;
  localparam kind_t KIND_MBC3 = 3'd3;
  localparam kind_t KIND_MBC5 = 3'd4;

  localparam target_t TGT_NONE = 2'd0;
  localparam target_t TGT_ROM  = 2'd1;
  localparam target_t TGT_XRAM = 2'd2;
  localparam target_t TGT_INT  = 2'd3;

  localparam reg_idx_t REG_KIND      = 2'd0;
  localparam reg_idx_t REG_BANK_MASK = 2'd1;
  localparam reg_idx_t REG_ROM_BYTES = 2'd2;

  // control-write windows, by address bits 14:13
  localparam logic [1:0] WIN_RAM_EN   = 2'd0;
  localparam logic [1:0] WIN_ROM_BANK = 2'd1;
  localparam logic [1:0] WIN_RAM_BANK = 2'd2;

  localparam logic [3:0]  RAM_EN_KEY   = 4'hA;
  localparam logic [3:0]  CLK_BANK_LO  = 4'h8;
  localparam logic [3:0]  CLK_BANK_HI  = 4'hC;
  localparam logic [23:0] ROM_FIXED    = 24'h008000;
  localparam logic [7:0]  OPEN_BUS     = 8'hFF;
  localparam logic [3:0]  NIBBLE_PAD   = 4'hF;

  typedef struct packed {
    logic [8:0] rom_page;
    logic [3:0] ram_page;
    logic       mode;
    logic       ram_en;
  } bank_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/cartridge_bank_mapper_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel    Ports                                        Direction
// ---------  -------------------------------------------  ---------
// request    in_valid/in_stall, in_req_type, in_bus_*     in
// result     out_valid/out_stall, out_target, out_phys_*  out
// config     cfg_psel/penable/pwrite/paddr/pwdata/...     APB
//
// One transfer per cycle unless stalled; each passes the input register, then the result register.
// After reset the nibble RAM is zeroed one entry a cycle, all NIBBLE_DEPTH
// (512) entries, with in_stall high; configuration writes are taken throughout.
// A stalled result holds; the input register keeps accepting while the result
// register drains.

module cartridge_bank_mapper_top #(
  parameter int EXT_RAM_BYTES = 32768,
  parameter int NIBBLE_DEPTH  = 512
) (
  input  wire         clk,
  input  wire         rst_n,

  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_req_type,
  input  wire  [15:0] in_bus_address,
  input  wire  [7:0]  in_bus_wdata,

  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_target,
  output logic [22:0] out_phys_address,
  output logic        out_mem_write,
  output logic [7:0]  out_mem_wdata,
  output logic [7:0]  out_rdata,

  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [3:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import cbm_pkg::*;

  localparam int          IDX_W   = $clog2(NIBBLE_DEPTH);
  localparam logic [17:0] EXT_LIM = 18'(EXT_RAM_BYTES);

  // configuration
  kind_t       cfg_kind_r;
  logic [8:0]  cfg_mask_r;
  logic [23:0] cfg_rom_bytes_r;
  logic        cfg_wr;

  // clearing pass
  logic             clr_busy_r;
  logic [IDX_W-1:0] clr_idx_r;

  // input register
  logic        s1_valid_r;
  logic        s1_wr_r;
  logic [15:0] s1_addr_r;
  logic [7:0]  s1_wdata_r;
  logic        s1_adv;
  logic        commit;
  logic        in_acc;

  // nibble RAM
  logic [3:0]       nib_mem [NIBBLE_DEPTH];
  logic [3:0]       nib_q_r;
  logic             fwd_hit_r;
  logic [3:0]       fwd_data_r;
  logic             nib_we;
  logic [IDX_W-1:0] nib_widx;
  logic [IDX_W-1:0] in_idx;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [3:0]       mem_wdata;
  logic [3:0]       nib_val;

  // mapper state
  bank_state_t st_r, st_nxt;
  logic [7:0]  clk_regs_r [5];
  logic        clk_we;
  logic [2:0]  clk_idx;

  // decode
  kind_t       kind;
  logic        is_ext;
  logic        xram_on;
  logic        clk_sel;
  logic [23:0] rom_ext;
  logic [8:0]  eff_bank;
  logic [8:0]  bank_m2;
  logic [22:0] rom_off;
  logic [3:0]  ram_sel;
  logic [16:0] ram_off;
  logic [4:0]  b5;
  logic [6:0]  b7;
  logic [3:0]  b4;

  // result register
  logic        out_valid_r;
  logic [1:0]  out_target_r, out_target_nxt;
  logic [22:0] out_phys_r, out_phys_nxt;
  logic        out_mw_r, out_mw_nxt;
  logic [7:0]  out_mwd_r, out_mwd_nxt;
  logic [7:0]  out_rd_r, out_rd_nxt;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_kind_r      <= KIND_ROM;
      cfg_mask_r      <= 9'd1;
      cfg_rom_bytes_r <= 24'd32768;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_KIND:      cfg_kind_r      <= cfg_pwdata[2:0];
        REG_BANK_MASK: cfg_mask_r      <= cfg_pwdata[8:0];
        REG_ROM_BYTES: cfg_rom_bytes_r <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_KIND:      cfg_prdata = {29'd0, cfg_kind_r};
      REG_BANK_MASK: cfg_prdata = {23'd0, cfg_mask_r};
      REG_ROM_BYTES: cfg_prdata = {8'd0, cfg_rom_bytes_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- handshake
  assign s1_adv   = ~out_valid_r | ~out_stall;
  assign commit   = s1_valid_r & s1_adv;
  assign in_stall = clr_busy_r | (s1_valid_r & ~s1_adv);
  assign in_acc   = in_valid & ~in_stall;
  assign in_idx   = in_bus_address[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_wr_r    <= in_req_type;
      s1_addr_r  <= in_bus_address;
      s1_wdata_r <= in_bus_wdata;
    end
  end

  // ---------------------------------------------------------------- nibble RAM
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (&clr_idx_r) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  assign mem_we    = clr_busy_r | nib_we;
  assign mem_waddr = clr_busy_r ? clr_idx_r : nib_widx;
  assign mem_wdata = clr_busy_r ? 4'd0 : s1_wdata_r[3:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      nib_mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      nib_q_r <= nib_mem[in_idx];
    end
  end

  // a write landing at the same edge as the read is not seen by it: forward
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (in_acc) begin
      fwd_hit_r <= nib_we & (nib_widx == in_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fwd_data_r <= s1_wdata_r[3:0];
    end
  end

  assign nib_val = fwd_hit_r ? fwd_data_r : nib_q_r;

  // ---------------------------------------------------------------- decode
  assign kind     = (cfg_kind_r > KIND_MBC5) ? KIND_ROM : cfg_kind_r;
  assign is_ext   = (s1_addr_r[15:13] == 3'b101);
  assign xram_on  = is_ext & st_r.ram_en;
  assign clk_sel  = (kind == KIND_MBC3) && (st_r.ram_page >= CLK_BANK_LO)
                    && (st_r.ram_page <= CLK_BANK_HI);
  assign clk_idx  = st_r.ram_page[2:0];
  assign nib_widx = s1_addr_r[IDX_W-1:0];
  assign nib_we   = commit & xram_on & (kind == KIND_MBC2) & s1_wr_r;
  assign clk_we   = commit & xram_on & (kind != KIND_MBC2) & clk_sel & s1_wr_r;

  assign rom_ext  = (cfg_rom_bytes_r > ROM_FIXED) ? cfg_rom_bytes_r - ROM_FIXED : 24'd0;
  assign eff_bank = (st_r.rom_page == 9'd0) ? 9'd1 : st_r.rom_page;
  assign bank_m2  = eff_bank - 9'd2;
  assign rom_off  = {bank_m2, s1_addr_r[13:0]};
  assign ram_sel  = (kind == KIND_MBC1 && !st_r.mode) ? 4'd0 : st_r.ram_page;
  assign ram_off  = {ram_sel, s1_addr_r[12:0]};

  assign b5 = (s1_wdata_r[4:0] == 5'd0) ? 5'd1 : s1_wdata_r[4:0];
  assign b7 = (s1_wdata_r[6:0] == 7'd0) ? 7'd1 : s1_wdata_r[6:0];
  assign b4 = (s1_wdata_r[3:0] == 4'd0) ? 4'd1 : s1_wdata_r[3:0];

  // control register writes
  always_comb begin
    st_nxt = st_r;
    if (s1_wr_r && !s1_addr_r[15]) begin
      case (s1_addr_r[14:13])
        WIN_RAM_EN: begin
          if (kind != KIND_ROM && (kind != KIND_MBC2 || !s1_addr_r[8])) begin
            st_nxt.ram_en = (s1_wdata_r[3:0] == RAM_EN_KEY);
          end
        end
        WIN_ROM_BANK: begin
          case (kind)
            KIND_MBC1: st_nxt.rom_page = {st_r.rom_page[8:5], b5} & cfg_mask_r
                                         & 9'h0FF;
            KIND_MBC2: begin
              if (s1_addr_r[8]) begin
                st_nxt.rom_page = {5'd0, b4};
              end
            end
            KIND_MBC3: st_nxt.rom_page = {2'd0, b7} & cfg_mask_r;
            KIND_MBC5: begin
              if (!s1_addr_r[12]) begin
                st_nxt.rom_page = {st_r.rom_page[8], s1_wdata_r} & cfg_mask_r;
              end else begin
                st_nxt.rom_page = {s1_wdata_r[0], st_r.rom_page[7:0]} & cfg_mask_r;
              end
            end
            default: ;
          endcase
        end
        WIN_RAM_BANK: begin
          if (kind == KIND_MBC1) begin
            if (!st_r.mode) begin
              st_nxt.rom_page = {2'd0, s1_wdata_r[1:0], st_r.rom_page[4:0]} & cfg_mask_r;
            end else begin
              st_nxt.ram_page = {2'd0, s1_wdata_r[1:0]};
            end
          end else if (kind == KIND_MBC3 || kind == KIND_MBC5) begin
            st_nxt.ram_page = s1_wdata_r[3:0];
          end
        end
        default: begin
          if (kind == KIND_MBC1) begin
            st_nxt.mode = s1_wdata_r[0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{rom_page: 9'd1, ram_page: 4'd0, mode: 1'b0, ram_en: 1'b0};
    end else if (commit) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) begin
        clk_regs_r[i] <= 8'd0;
      end
    end else if (clk_we) begin
      clk_regs_r[clk_idx] <= s1_wdata_r;
    end
  end

  // result
  always_comb begin
    out_target_nxt = TGT_NONE;
    out_phys_nxt   = 23'd0;
    out_mw_nxt     = 1'b0;
    out_mwd_nxt    = 8'd0;
    out_rd_nxt     = OPEN_BUS;
    if (!s1_addr_r[15]) begin
      if (!s1_wr_r) begin
        if (!s1_addr_r[14] || kind == KIND_ROM || rom_ext == 24'd0 || eff_bank == 9'd1) begin
          out_target_nxt = TGT_ROM;
          out_phys_nxt   = {7'd0, s1_addr_r};
          out_rd_nxt     = 8'd0;
        end else if ({1'b0, rom_off} < rom_ext) begin
          out_target_nxt = TGT_ROM;
          out_phys_nxt   = rom_off + ROM_FIXED[22:0];
          out_rd_nxt     = 8'd0;
        end
      end
    end else if (xram_on) begin
      if (kind == KIND_MBC2) begin
        out_target_nxt = TGT_INT;
        out_rd_nxt     = s1_wr_r ? 8'd0 : {NIBBLE_PAD, nib_val};
      end else if (clk_sel) begin
        out_target_nxt = TGT_INT;
        out_rd_nxt     = s1_wr_r ? 8'd0 : clk_regs_r[clk_idx];
      end else if ({1'b0, ram_off} < EXT_LIM) begin
        out_target_nxt = TGT_XRAM;
        out_phys_nxt   = {6'd0, ram_off};
        out_rd_nxt     = 8'd0;
        out_mw_nxt     = s1_wr_r;
        out_mwd_nxt    = s1_wr_r ? s1_wdata_r : 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_target_r <= out_target_nxt;
      out_phys_r   <= out_phys_nxt;
      out_mw_r     <= out_mw_nxt;
      out_mwd_r    <= out_mwd_nxt;
      out_rd_r     <= out_rd_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_target       = out_target_r;
  assign out_phys_address = out_phys_r;
  assign out_mem_write    = out_mw_r;
  assign out_mem_wdata    = out_mwd_r;
  assign out_rdata        = out_rd_r;

endmodule

`default_nettype wire
